// ===== sv/dpfh_pkg.sv =====
package dpfh_pkg;

  // Residency of a virtual page.
  typedef enum logic [1:0] {
    PG_FREE = 2'd0,
    PG_RAM  = 2'd1,
    PG_SWAP = 2'd2
  } page_state_e;

  typedef enum logic [1:0] {
    PROT_NONE = 2'd0,
    PROT_READ = 2'd1,
    PROT_RW   = 2'd2
  } prot_e;

  typedef enum logic [1:0] {
    STAT_MAPPED_NEW    = 2'd0,
    STAT_SWAPPED_IN    = 2'd1,
    STAT_MADE_WRITABLE = 2'd2,
    STAT_OUT_OF_RANGE  = 2'd3
  } status_e;

  localparam logic [0:0] CFG_FRAMES_IN_USE = 1'b0;
  localparam logic [0:0] CFG_PAGES_IN_USE  = 1'b1;

  localparam int unsigned CFG_DATA_W   = 9;
  localparam int unsigned FRAMES_CFG_W = 7;
  localparam int unsigned PAGES_CFG_W  = 9;
  localparam int unsigned PAGE_IDX_W   = 8;
  localparam int unsigned FRAME_OUT_W  = 6;

  localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = 7'd64;
  localparam logic [PAGES_CFG_W-1:0]  PAGES_RESET  = 9'd256;

  // Page table entry without its frame number.
  typedef struct packed {
    page_state_e state;
    page_state_e prev;
    logic        dirty;
    prot_e       prot;
  } page_meta_t;

  localparam int unsigned META_W = $bits(page_meta_t);

endpackage

// ===== sv/dpfh_page_ram.sv =====
module dpfh_page_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 13
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/demand_paging_fault_handler_core.sv =====
// Page fault handler. Each request names a virtual page; the block answers with one result
// that tells whether the page was newly mapped, swapped back in, made writable or was out of
// range, the frame now holding it and, when frame 0 had to be reclaimed, which page went to
// swap and whether its contents need writing back. Frames are handed out lowest first; since
// a frame is never released except frame 0 on reclaim, the owned frames always form a prefix
// and a fill count replaces any search. A request passes from S_IDLE through S_DEC, then
// S_EVICT when frame 0 is reclaimed, to S_OUT, or straight to S_OUT when the page is out of
// range; the result register is loaded at the end of S_OUT and the next request is taken
// in the cycle after it. A result still waiting in the result register holds the block in
// S_OUT. This sequence is set by the page table RAM, which has one write port and one
// registered read port: one read of the faulting page, a write of it together with a read
// of the victim, then the victim write. After reset the block clears every page table entry
// and takes no request meanwhile; configuration writes are taken at any time.
module demand_paging_fault_handler_core #(
  parameter int unsigned MAX_PAGES  = 256,
  parameter int unsigned MAX_FRAMES = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  input  logic                                   cfg_we_i,
  input  logic [0:0]                             cfg_index_i,
  input  logic [dpfh_pkg::CFG_DATA_W-1:0]        cfg_data_i,

  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [dpfh_pkg::PAGE_IDX_W-1:0]        page_index_i,

  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [1:0]                             status_o,
  output logic [dpfh_pkg::FRAME_OUT_W-1:0]       frame_o,
  output logic [1:0]                             new_protection_o,
  output logic                                   evicted_o,
  output logic [dpfh_pkg::PAGE_IDX_W-1:0]        evicted_page_o,
  output logic                                   write_back_o
);

  localparam int unsigned AW     = $clog2(MAX_PAGES);
  localparam int unsigned FW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned KW     = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CW     = (KW > dpfh_pkg::FRAMES_CFG_W) ? KW : dpfh_pkg::FRAMES_CFG_W;
  localparam int unsigned DW     = dpfh_pkg::META_W + FW;
  localparam logic [AW-1:0] LAST_PAGE = AW'(MAX_PAGES - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DEC   = 5'b00100,
    S_EVICT = 5'b01000,
    S_OUT   = 5'b10000
  } fsm_e;

  fsm_e state_q, state_d;

  logic [dpfh_pkg::FRAMES_CFG_W-1:0] frames_q;
  logic [dpfh_pkg::PAGES_CFG_W-1:0]  pages_q;

  logic [AW-1:0] clr_q;
  logic [KW-1:0] fill_q;
  logic [AW-1:0] owner0_q;
  logic [AW-1:0] page_q;
  logic [AW-1:0] vic_q;

  dpfh_pkg::status_e res_status_q;
  logic [dpfh_pkg::FRAME_OUT_W-1:0] res_frame_q;
  dpfh_pkg::prot_e res_prot_q;
  logic res_ev_q;
  logic [dpfh_pkg::PAGE_IDX_W-1:0] res_ev_page_q;
  logic res_wb_q;

  logic out_valid_q;
  dpfh_pkg::status_e out_status_q;
  logic [dpfh_pkg::FRAME_OUT_W-1:0] out_frame_q;
  dpfh_pkg::prot_e out_prot_q;
  logic out_ev_q;
  logic [dpfh_pkg::PAGE_IDX_W-1:0] out_ev_page_q;
  logic out_wb_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  dpfh_pkg::page_meta_t rd_meta;
  logic [FW-1:0]        rd_frame;
  dpfh_pkg::page_meta_t wr_meta;
  logic [FW-1:0]        wr_frame;

  logic          accept;
  logic          out_of_range;
  logic [CW-1:0] nlim;
  logic          have_free;
  logic          need_evict;
  logic [FW-1:0] take_frame;
  logic          page_resident;
  logic          out_free;

  dpfh_page_ram #(
    .DEPTH  (MAX_PAGES),
    .ADDR_W (AW),
    .DATA_W (DW)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_meta   = dpfh_pkg::page_meta_t'(mem_rdata[DW-1:FW]);
  assign rd_frame  = mem_rdata[FW-1:0];
  assign mem_wdata = {wr_meta, wr_frame};

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign out_of_range = ({1'b0, page_index_i} >= pages_q) ||
                        (32'(page_index_i) >= 32'(MAX_PAGES));

  // Frames in use are limited to what the frame table can hold.
  assign nlim = (CW'(frames_q) < CW'(MAX_FRAMES)) ? CW'(frames_q) : CW'(MAX_FRAMES);
  assign have_free  = CW'(fill_q) < nlim;
  assign need_evict = !have_free && (fill_q != '0);
  assign take_frame = have_free ? FW'(fill_q) : '0;

  always_comb begin
    page_resident = 1'b1;
    case (rd_meta.state) inside
      dpfh_pkg::PG_FREE, dpfh_pkg::PG_SWAP: page_resident = 1'b0;
      default:                              page_resident = 1'b1;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = page_q;
    mem_raddr = AW'(page_index_i);
    wr_meta   = rd_meta;
    wr_frame  = rd_frame;
    unique case (state_q)
      S_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = clr_q;
        wr_meta.state  = dpfh_pkg::PG_FREE;
        wr_meta.prev   = dpfh_pkg::PG_FREE;
        wr_meta.dirty  = 1'b0;
        wr_meta.prot   = dpfh_pkg::PROT_NONE;
        wr_frame       = '0;
      end
      S_DEC: begin
        mem_we       = 1'b1;
        mem_waddr    = page_q;
        mem_raddr    = owner0_q;
        wr_meta.prev = rd_meta.state;
        if (page_resident) begin
          wr_meta.prot  = dpfh_pkg::PROT_RW;
          wr_meta.dirty = 1'b1;
        end else begin
          wr_meta.state = dpfh_pkg::PG_RAM;
          wr_frame      = take_frame;
          if (rd_meta.state == dpfh_pkg::PG_FREE) begin
            wr_meta.prot = dpfh_pkg::PROT_READ;
          end
        end
      end
      S_EVICT: begin
        mem_we        = 1'b1;
        mem_waddr     = vic_q;
        wr_meta.prev  = rd_meta.state;
        wr_meta.state = dpfh_pkg::PG_SWAP;
        wr_meta.dirty = 1'b0;
      end
      S_IDLE, S_OUT: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == LAST_PAGE) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = out_of_range ? S_OUT : S_DEC;
      S_DEC:   state_d = (!page_resident && need_evict) ? S_EVICT : S_OUT;
      S_EVICT: state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      frames_q    <= dpfh_pkg::FRAMES_RESET;
      pages_q     <= dpfh_pkg::PAGES_RESET;
      clr_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dpfh_pkg::CFG_FRAMES_IN_USE: frames_q <= cfg_data_i[dpfh_pkg::FRAMES_CFG_W-1:0];
          dpfh_pkg::CFG_PAGES_IN_USE:  pages_q  <= cfg_data_i[dpfh_pkg::PAGES_CFG_W-1:0];
          default:                     pages_q  <= pages_q;
        endcase
      end

      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end

      if ((state_q == S_DEC) && !page_resident) begin
        if (have_free) begin
          fill_q <= fill_q + 1'b1;
        end else if (fill_q == '0) begin
          fill_q <= KW'(1);
        end
      end

      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= AW'(page_index_i);
      if (out_of_range) begin
        res_status_q  <= dpfh_pkg::STAT_OUT_OF_RANGE;
        res_frame_q   <= '0;
        res_prot_q    <= dpfh_pkg::PROT_NONE;
        res_ev_q      <= 1'b0;
        res_ev_page_q <= '0;
        res_wb_q      <= 1'b0;
      end
    end

    if (state_q == S_DEC) begin
      res_wb_q <= 1'b0;
      if (page_resident) begin
        res_status_q  <= dpfh_pkg::STAT_MADE_WRITABLE;
        res_frame_q   <= dpfh_pkg::FRAME_OUT_W'(rd_frame);
        res_prot_q    <= dpfh_pkg::PROT_RW;
        res_ev_q      <= 1'b0;
        res_ev_page_q <= '0;
      end else begin
        res_status_q <= (rd_meta.state == dpfh_pkg::PG_FREE) ?
                        dpfh_pkg::STAT_MAPPED_NEW : dpfh_pkg::STAT_SWAPPED_IN;
        res_frame_q  <= dpfh_pkg::FRAME_OUT_W'(take_frame);
        res_prot_q   <= (rd_meta.state == dpfh_pkg::PG_FREE) ?
                        dpfh_pkg::PROT_READ : rd_meta.prot;
        res_ev_q      <= need_evict;
        res_ev_page_q <= need_evict ? dpfh_pkg::PAGE_IDX_W'(owner0_q) : '0;
        vic_q         <= owner0_q;
        // Frame 0 changes hands whenever it is the frame taken, the very first time included.
        if (!have_free || (fill_q == '0)) begin
          owner0_q <= page_q;
        end
      end
    end

    if (state_q == S_EVICT) begin
      res_wb_q <= (rd_meta.prev == dpfh_pkg::PG_FREE) || rd_meta.dirty;
    end

    if ((state_q == S_OUT) && out_free) begin
      out_status_q  <= res_status_q;
      out_frame_q   <= res_frame_q;
      out_prot_q    <= res_prot_q;
      out_ev_q      <= res_ev_q;
      out_ev_page_q <= res_ev_page_q;
      out_wb_q      <= res_wb_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign frame_o          = out_frame_q;
  assign new_protection_o = out_prot_q;
  assign evicted_o        = out_ev_q;
  assign evicted_page_o   = out_ev_page_q;
  assign write_back_o     = out_wb_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TB_PAGES  = 256;
  localparam int unsigned TB_FRAMES = 64;

  typedef struct packed {
    dpfh_pkg::status_e status;
    logic [5:0]        frame;
    dpfh_pkg::prot_e   prot;
    logic              evicted;
    logic [7:0]        evicted_page;
    logic              write_back;
  } fault_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_index_i;
  logic [8:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] page_index_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] status_o;
  logic [5:0] frame_o;
  logic [1:0] new_protection_o;
  logic       evicted_o;
  logic [7:0] evicted_page_o;
  logic       write_back_o;

  demand_paging_fault_handler_core #(
    .MAX_PAGES  (TB_PAGES),
    .MAX_FRAMES (TB_FRAMES)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .page_index_i     (page_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .frame_o          (frame_o),
    .new_protection_o (new_protection_o),
    .evicted_o        (evicted_o),
    .evicted_page_o   (evicted_page_o),
    .write_back_o     (write_back_o)
  );

  // Shadow copy of the page table and frame table.
  dpfh_pkg::page_state_e pg_state [TB_PAGES];
  dpfh_pkg::page_state_e pg_prev  [TB_PAGES];
  bit                    pg_dirty [TB_PAGES];
  dpfh_pkg::prot_e       pg_prot  [TB_PAGES];
  logic [5:0]            pg_frame [TB_PAGES];
  bit                    frm_owned [TB_FRAMES];
  logic [7:0]            frm_owner [TB_FRAMES];
  logic [6:0]            n_frames;
  logic [8:0]            n_pages;

  fault_result_t pending_faults[$];

  int n_errors;
  int n_faults;
  int n_evictions;
  int n_out_of_range;
  int n_settings;
  int send_idle_pct;
  int recv_idle_pct;
  int ready_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("** demand_paging_fault_handler_core: FAILED **");
    $finish;
  end

  function automatic void reset_tables();
    for (int i = 0; i < TB_PAGES; i++) begin
      pg_state[i] = dpfh_pkg::PG_FREE;
      pg_prev[i]  = dpfh_pkg::PG_FREE;
      pg_dirty[i] = 1'b0;
      pg_prot[i]  = dpfh_pkg::PROT_NONE;
      pg_frame[i] = '0;
    end
    for (int i = 0; i < TB_FRAMES; i++) begin
      frm_owned[i] = 1'b0;
      frm_owner[i] = '0;
    end
    n_frames = dpfh_pkg::FRAMES_RESET;
    n_pages  = dpfh_pkg::PAGES_RESET;
  endfunction

  // Applies one fault to the shadow tables and returns the result the block must give.
  function automatic fault_result_t handle_fault(logic [7:0] pg);
    fault_result_t res;
    int limit;
    int f;
    bit found;
    logic [7:0] victim;
    bit fresh;

    res = '0;
    res.status = dpfh_pkg::STAT_OUT_OF_RANGE;
    res.prot = dpfh_pkg::PROT_NONE;
    if ({1'b0, pg} >= n_pages) begin
      n_out_of_range++;
      return res;
    end
    if (pg_state[pg] == dpfh_pkg::PG_FREE || pg_state[pg] == dpfh_pkg::PG_SWAP) begin
      fresh = (pg_state[pg] == dpfh_pkg::PG_FREE);
      limit = (n_frames > 7'd64) ? int'(TB_FRAMES) : int'(n_frames);
      found = 1'b0;
      f = 0;
      for (int i = 0; i < limit; i++) begin
        if (!found && !frm_owned[i]) begin
          f = i;
          found = 1'b1;
        end
      end
      // With every frame taken, frame 0 is reclaimed from whoever holds it.
      if (!found && frm_owned[0]) begin
        victim = frm_owner[0];
        res.evicted = 1'b1;
        res.evicted_page = victim;
        res.write_back = (pg_prev[victim] == dpfh_pkg::PG_FREE) || pg_dirty[victim];
        pg_prev[victim] = pg_state[victim];
        pg_state[victim] = dpfh_pkg::PG_SWAP;
        pg_dirty[victim] = 1'b0;
        frm_owned[0] = 1'b0;
        n_evictions++;
      end
      pg_prev[pg] = pg_state[pg];
      pg_state[pg] = dpfh_pkg::PG_RAM;
      if (fresh) begin
        pg_prot[pg] = dpfh_pkg::PROT_READ;
        res.status = dpfh_pkg::STAT_MAPPED_NEW;
      end else begin
        res.status = dpfh_pkg::STAT_SWAPPED_IN;
      end
      pg_frame[pg] = f[5:0];
      frm_owner[f] = pg;
      frm_owned[f] = 1'b1;
      res.frame = f[5:0];
      res.prot = pg_prot[pg];
    end else begin
      pg_prev[pg] = pg_state[pg];
      pg_prot[pg] = dpfh_pkg::PROT_RW;
      pg_dirty[pg] = 1'b1;
      res.status = dpfh_pkg::STAT_MADE_WRITABLE;
      res.frame = pg_frame[pg];
      res.prot = dpfh_pkg::PROT_RW;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    fault_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_faults.size() == 0) begin
        $error("result with no request pending");
        n_errors++;
      end else begin
        want = pending_faults.pop_front();
        check_field("status", want.status, status_o);
        check_field("frame", want.frame, frame_o);
        check_field("new_protection", want.prot, new_protection_o);
        check_field("evicted", want.evicted, evicted_o);
        check_field("evicted_page", want.evicted_page, evicted_page_o);
        check_field("write_back", want.write_back, write_back_o);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (ready_hold > 0) begin
        out_ready_i = 1'b0;
        repeat (ready_hold - 1) @(negedge clk_i);
        ready_hold = 0;
      end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_fault(logic [7:0] pg);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    page_index_i = pg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_faults.push_back(handle_fault(pg));
    n_faults++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [8:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == dpfh_pkg::CFG_FRAMES_IN_USE) n_frames = val[6:0];
    else n_pages = val;
    n_settings++;
  endtask

  // Lowers valid and lets every outstanding request come back before a register write.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_faults.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [8:0] frames, logic [8:0] pages, int count, int span,
                           int idle_pct);
    drain();
    write_reg(dpfh_pkg::CFG_FRAMES_IN_USE, frames);
    write_reg(dpfh_pkg::CFG_PAGES_IN_USE, pages);
    send_idle_pct = idle_pct;
    recv_idle_pct = idle_pct;
    // Mostly pages from a working set near the frame count, now and then any page.
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) send_fault(8'($urandom_range(0, 255)));
      else send_fault(8'($urandom_range(0, span - 1)));
    end
  endtask

  // With no frames at all, frame 0 starts out unowned and is then handed around.
  task automatic test_unowned_victim();
    write_reg(dpfh_pkg::CFG_FRAMES_IN_USE, 9'd0);
    write_reg(dpfh_pkg::CFG_PAGES_IN_USE, 9'd16);
    send_fault(8'd5);
    send_fault(8'd6);
    send_fault(8'd5);
    send_fault(8'd5);
    send_fault(8'd7);
    send_fault(8'd5);
    send_fault(8'd7);
    send_fault(8'd15);
    send_fault(8'd16);
  endtask

  task automatic test_range_limits();
    drain();
    write_reg(dpfh_pkg::CFG_PAGES_IN_USE, 9'd0);
    send_fault(8'd0);
    send_fault(8'd255);
    drain();
    write_reg(dpfh_pkg::CFG_PAGES_IN_USE, 9'd1);
    send_fault(8'd0);
    send_fault(8'd1);
    drain();
    // Frame count beyond the table size and the widest page count.
    write_reg(dpfh_pkg::CFG_FRAMES_IN_USE, 9'd127);
    write_reg(dpfh_pkg::CFG_PAGES_IN_USE, 9'd511);
    send_fault(8'd255);
    send_fault(8'd128);
    send_fault(8'd255);
    send_fault(8'd0);
    drain();
    // Bits above the frame count field are dropped, leaving 64.
    write_reg(dpfh_pkg::CFG_FRAMES_IN_USE, 9'h1C0);
    write_reg(dpfh_pkg::CFG_PAGES_IN_USE, 9'd256);
    send_fault(8'd170);
    send_fault(8'd85);
  endtask

  task automatic test_random_mix();
    run_phase(9'd64, 9'd256, 150, 256, 25);
    run_phase(9'd4, 9'd16, 180, 20, 30);
    run_phase(9'd1, 9'd8, 140, 10, 0);
    run_phase(9'd127, 9'd511, 130, 256, 20);
    run_phase(9'd0, 9'd32, 90, 36, 30);
    run_phase(9'($urandom_range(1, 64)), 9'($urandom_range(1, 256)), 120, 64, 40);
    run_phase(9'd64, 9'd256, 100, 80, 15);
  endtask

  task automatic test_backpressure();
    drain();
    write_reg(dpfh_pkg::CFG_FRAMES_IN_USE, 9'd8);
    write_reg(dpfh_pkg::CFG_PAGES_IN_USE, 9'd64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    ready_hold = 200;
    repeat (60) send_fault(8'($urandom_range(0, 70)));
  endtask

  task automatic test_steady_stream();
    run_phase(9'd16, 9'd100, 140, 110, 0);
  endtask

  initial begin : main
    int waited;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    page_index_i = '0;
    n_errors = 0;
    n_faults = 0;
    n_evictions = 0;
    n_out_of_range = 0;
    n_settings = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    ready_hold = 0;
    reset_tables();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_unowned_victim();
    test_range_limits();
    test_random_mix();
    test_backpressure();
    test_steady_stream();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    waited = 0;
    while (pending_faults.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_faults.size() != 0) begin
      $error("%0d results never arrived", pending_faults.size());
      n_errors++;
    end
    repeat (10) @(posedge clk_i);

    $display("Sent %0d page faults under %0d register writes: %0d reclaims of frame 0,",
             n_faults, n_settings, n_evictions);
    $display("%0d out-of-range pages, one long result stall; %0d mismatches.",
             n_out_of_range, n_errors);
    if (n_errors == 0) begin
      $display("** demand_paging_fault_handler_core: PASSED **");
    end else begin
      $display("** demand_paging_fault_handler_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dpfh_pkg.sv
sv/dpfh_page_ram.sv
sv/demand_paging_fault_handler_core.sv
tb/sv/tb.sv
